### rtl/aqrt_pkg.sv
// ----------------------------------------------------------------------------
// aqrt_pkg
// Shared constants, types and codes of the aggressor row quarantine tracker.
// ----------------------------------------------------------------------------
package aqrt_pkg;

    localparam int NUM_BANKS   = 16;
    localparam int TRACK_DEPTH = 32;
    localparam int MAX_QROWS   = 256;
    localparam int ROW_BITS    = 16;

    localparam int BANK_W  = 4;
    localparam int ROWF_W  = 16;
    localparam int KIND_W  = 2;

    localparam int TRK_WORDS = NUM_BANKS * TRACK_DEPTH;
    localparam int REV_WORDS = NUM_BANKS * MAX_QROWS;
    localparam int TRK_AW    = $clog2(TRK_WORDS);
    localparam int REV_AW    = $clog2(REV_WORDS);
    localparam int TRK_IW    = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int TRK_CW    = $clog2(TRACK_DEPTH + 1);
    localparam int SLOT_W    = (MAX_QROWS > 1) ? $clog2(MAX_QROWS) : 1;
    localparam int TRK_DW    = 1 + ROW_BITS + 32;
    localparam int REV_DW    = 1 + ROW_BITS;
    localparam int CLR_W     = REV_AW + 1;

    localparam int PADDR_W = 4;

    // register indexes
    localparam logic [1:0] REG_TRACKER_ENTRIES   = 2'd0;
    localparam logic [1:0] REG_MIGRATE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_QUARANTINE_ROWS   = 2'd2;
    localparam logic [1:0] REG_EPOCH_TICKS       = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MIGRATE = 2'd2;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ACT  = 1'b1;

    typedef struct packed {
        logic [5:0]  tracker_entries;
        logic [15:0] migrate_threshold;
        logic [8:0]  quarantine_rows;
        logic [31:0] epoch_ticks;
    } cfg_t;

endpackage

### rtl/aqrt_ram.sv
// ----------------------------------------------------------------------------
// aqrt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module aqrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/aqrt_div.sv
// ----------------------------------------------------------------------------
// aqrt_div
// Restoring 32-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aqrt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] remainder
);
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // one shift and conditional subtract per cycle
    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[31]};
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[31:0];
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

### rtl/aqrt_cfg.sv
// ----------------------------------------------------------------------------
// aqrt_cfg
// APB-style register file holding the four configuration registers.
// ----------------------------------------------------------------------------
module aqrt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aqrt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output aqrt_pkg::cfg_t              cfg
);
    import aqrt_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // take a register write on the access cycle
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TRACKER_ENTRIES:   cfg_next.tracker_entries   = pwdata[5:0];
                REG_MIGRATE_THRESHOLD: cfg_next.migrate_threshold = pwdata[15:0];
                REG_QUARANTINE_ROWS:   cfg_next.quarantine_rows   = pwdata[8:0];
                REG_EPOCH_TICKS:       cfg_next.epoch_ticks       = pwdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            REG_TRACKER_ENTRIES:   prdata = {26'd0, cfg_reg.tracker_entries};
            REG_MIGRATE_THRESHOLD: prdata = {16'd0, cfg_reg.migrate_threshold};
            REG_QUARANTINE_ROWS:   prdata = {23'd0, cfg_reg.quarantine_rows};
            REG_EPOCH_TICKS:       prdata = cfg_reg.epoch_ticks;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tracker_entries   <= 6'd32;
            cfg_reg.migrate_threshold <= 16'd512;
            cfg_reg.quarantine_rows   <= 9'd256;
            cfg_reg.epoch_ticks       <= 32'd102400000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

### rtl/aggressor_row_quarantine_tracker.sv
// ----------------------------------------------------------------------------
// aggressor_row_quarantine_tracker
// Per-bank aggressor tracking with spillover eviction and quarantine
// migration through a rotating head slot and per-bank reverse table.
// ----------------------------------------------------------------------------
//  channel | signals                         | content
//  --------+---------------------------------+------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | tuser cmd, tdata bank,row
//  output  | m_tvalid m_tready m_tdata m_tuser m_tlast | tuser kind, tdata
//          |                                 |   out_bank,first_row,second_row
//  config  | psel penable pwrite paddr pwdata prdata pready | 4 registers
//
//  An activation runs the tracker scan (one table read a cycle over 32
//  entries), then the threshold remainder, and on a migration the
//  reverse-table accesses, up to five result transfers and the head wrap
//  remainder. A tick runs the epoch remainder when an epoch length is set.
//  After reset a clearing pass sweeps both tables; an epoch end sweeps the
//  tracker table. No input is taken meanwhile.
//  A stalled output holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module aggressor_row_quarantine_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // bank[3:0], row[19:4]
    input  logic                         s_tuser,  // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,  // out_bank, first_row, second_row
    output logic [1:0]                   m_tuser,  // kind
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aqrt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import aqrt_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CLR  = 5'd1;
    localparam logic [4:0] ST_TDIV = 5'd2;
    localparam logic [4:0] ST_SCAN = 5'd3;
    localparam logic [4:0] ST_DEC  = 5'd4;
    localparam logic [4:0] ST_MDIV = 5'd5;
    localparam logic [4:0] ST_QRD  = 5'd6;
    localparam logic [4:0] ST_QCHK = 5'd7;
    localparam logic [4:0] ST_ERMQ = 5'd8;
    localparam logic [4:0] ST_EMGQ = 5'd9;
    localparam logic [4:0] ST_RRD  = 5'd10;
    localparam logic [4:0] ST_RCHK = 5'd11;
    localparam logic [4:0] ST_RWR  = 5'd12;
    localparam logic [4:0] ST_ERMR = 5'd13;
    localparam logic [4:0] ST_EINS = 5'd14;
    localparam logic [4:0] ST_EFIN = 5'd15;
    localparam logic [4:0] ST_HDIV = 5'd16;

    cfg_t cfg;

    logic [4:0]          state_reg, state_next;
    logic [BANK_W-1:0]   bank_reg, bank_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [TRK_CW-1:0]   scan_idx_reg, scan_idx_next;
    logic                scan_pend_reg, scan_pend_next;
    logic [TRK_IW-1:0]   scan_pidx_reg, scan_pidx_next;
    logic [TRK_CW-1:0]   used_reg, used_next;
    logic                hit_f_reg, hit_f_next, free_f_reg, free_f_next, ev_f_reg, ev_f_next;
    logic [TRK_IW-1:0]   hit_i_reg, hit_i_next, free_i_reg, free_i_next, ev_i_reg, ev_i_next;
    logic [31:0]         hit_cnt_reg, hit_cnt_next;
    logic [31:0]         cnt_reg, cnt_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [31:0]         tick_reg, tick_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                clr_rev_reg, clr_rev_next;
    logic [31:0]         spill_reg [NUM_BANKS];
    logic [31:0]         spill_next [NUM_BANKS];
    logic [ROW_BITS-1:0] prev_reg, prev_next;
    logic [ROW_BITS-1:0] ins_reg, ins_next;

    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [BANK_W-1:0]   out_bank_reg, out_bank_next;
    logic [ROWF_W-1:0]   out_first_reg, out_first_next;
    logic [ROWF_W-1:0]   out_second_reg, out_second_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;

    logic              trk_we;
    logic [TRK_AW-1:0] trk_waddr, trk_raddr;
    logic [TRK_DW-1:0] trk_wdata, trk_rdata;
    logic              rev_we;
    logic [REV_AW-1:0] rev_waddr, rev_raddr;
    logic [REV_DW-1:0] rev_wdata, rev_rdata;

    logic        div_start, div_busy, div_done;
    logic [31:0] div_dvd, div_dvs, div_rem;

    logic [TRK_CW-1:0]   cap;
    logic [8:0]          qrows;
    logic [ROWF_W-1:0]   slot_row;
    logic [31:0]         spill_cur;
    logic                rd_v;
    logic [ROW_BITS-1:0] rd_row;
    logic [31:0]         rd_cnt;
    logic                acc;

    aqrt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aqrt_ram #(.WIDTH(TRK_DW), .DEPTH(TRK_WORDS)) u_trk_ram (
        .clk   (clk),
        .we    (trk_we),
        .waddr (trk_waddr),
        .wdata (trk_wdata),
        .raddr (trk_raddr),
        .rdata (trk_rdata)
    );

    aqrt_ram #(.WIDTH(REV_DW), .DEPTH(REV_WORDS)) u_rev_ram (
        .clk   (clk),
        .we    (rev_we),
        .waddr (rev_waddr),
        .wdata (rev_wdata),
        .raddr (rev_raddr),
        .rdata (rev_rdata)
    );

    aqrt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // effective sizes
    assign cap = (32'(cfg.tracker_entries) > TRACK_DEPTH) ? TRK_CW'(TRACK_DEPTH)
                                                           : TRK_CW'(cfg.tracker_entries);
    always_comb
    begin
        if (cfg.quarantine_rows == 9'd0)
        begin
            qrows = 9'd1;
        end
        else if (32'(cfg.quarantine_rows) > MAX_QROWS)
        begin
            qrows = 9'(MAX_QROWS);
        end
        else
        begin
            qrows = cfg.quarantine_rows;
        end
    end

    assign slot_row  = ROWF_W'(head_reg);
    assign spill_cur = spill_reg[bank_reg];
    assign rd_v      = trk_rdata[TRK_DW-1];
    assign rd_row    = trk_rdata[TRK_DW-2:32];
    assign rd_cnt    = trk_rdata[31:0];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign acc       = s_tvalid && s_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        row_next        = row_reg;
        scan_idx_next   = scan_idx_reg;
        scan_pend_next  = 1'b0;
        scan_pidx_next  = scan_pidx_reg;
        used_next       = used_reg;
        hit_f_next      = hit_f_reg;
        hit_i_next      = hit_i_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_f_next     = free_f_reg;
        free_i_next     = free_i_reg;
        ev_f_next       = ev_f_reg;
        ev_i_next       = ev_i_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        tick_next       = tick_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_rev_next    = clr_rev_reg;
        spill_next      = spill_reg;
        prev_next       = prev_reg;
        ins_next        = ins_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_bank_next   = out_bank_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_last_next   = out_last_reg;
        trk_we          = 1'b0;
        trk_waddr       = TRK_AW'(32'(bank_reg) * TRACK_DEPTH);
        trk_wdata       = '0;
        trk_raddr       = TRK_AW'(32'(bank_reg) * TRACK_DEPTH + 32'(scan_idx_reg));
        rev_we          = 1'b0;
        rev_waddr       = REV_AW'(32'(bank_reg) * MAX_QROWS + 32'(head_reg));
        rev_wdata       = '0;
        rev_raddr       = REV_AW'(32'(bank_reg) * MAX_QROWS + 32'(head_reg));
        div_start       = 1'b0;
        div_dvd         = cnt_reg;
        div_dvs         = {16'd0, cfg.migrate_threshold};

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    bank_next = s_tdata[3:0];
                    row_next  = ROW_BITS'(s_tdata[19:4]);
                    if (s_tuser == CMD_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                        if (cfg.epoch_ticks != 32'd0)
                        begin
                            div_start  = 1'b1;
                            div_dvd    = tick_reg + 32'd1;
                            div_dvs    = cfg.epoch_ticks;
                            state_next = ST_TDIV;
                        end
                    end
                    else if (32'(s_tdata[3:0]) < NUM_BANKS)
                    begin
                        scan_idx_next = '0;
                        used_next     = '0;
                        hit_f_next    = 1'b0;
                        free_f_next   = 1'b0;
                        ev_f_next     = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            // sweep tables clear
            ST_CLR:
            begin
                if (32'(clr_cnt_reg) < TRK_WORDS)
                begin
                    trk_we    = 1'b1;
                    trk_waddr = TRK_AW'(clr_cnt_reg);
                end
                if (clr_rev_reg)
                begin
                    rev_we    = 1'b1;
                    rev_waddr = REV_AW'(clr_cnt_reg);
                end
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if ((clr_rev_reg && 32'(clr_cnt_reg) == REV_WORDS - 1) ||
                    (!clr_rev_reg && 32'(clr_cnt_reg) == TRK_WORDS - 1))
                begin
                    clr_rev_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            ST_TDIV:
            begin
                if (div_done)
                begin
                    if (div_rem == 32'd0)
                    begin
                        clr_cnt_next = '0;
                        clr_rev_next = 1'b0;
                        for (int b = 0; b < NUM_BANKS; b++)
                        begin
                            spill_next[b] = '0;
                        end
                        state_next = ST_CLR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // read one tracker entry per cycle, examine the previous one
            ST_SCAN:
            begin
                if (32'(scan_idx_reg) < TRACK_DEPTH)
                begin
                    scan_pend_next = 1'b1;
                    scan_pidx_next = TRK_IW'(scan_idx_reg);
                    scan_idx_next  = scan_idx_reg + TRK_CW'(1);
                end
                if (scan_pend_reg)
                begin
                    if (rd_v)
                    begin
                        used_next = used_reg + TRK_CW'(1);
                        if (!hit_f_reg && rd_row == row_reg)
                        begin
                            hit_f_next   = 1'b1;
                            hit_i_next   = scan_pidx_reg;
                            hit_cnt_next = rd_cnt;
                        end
                        if (!ev_f_reg && rd_cnt == spill_cur)
                        begin
                            ev_f_next = 1'b1;
                            ev_i_next = scan_pidx_reg;
                        end
                    end
                    else if (!free_f_reg)
                    begin
                        free_f_next = 1'b1;
                        free_i_next = scan_pidx_reg;
                    end
                end
                else if (32'(scan_idx_reg) == TRACK_DEPTH)
                begin
                    state_next = ST_DEC;
                end
            end

            // update the hit, free or evicted entry, else grow the bank's spillover count
            ST_DEC:
            begin
                state_next = ST_IDLE;
                if (hit_f_reg)
                begin
                    cnt_next  = (hit_cnt_reg == 32'hFFFF_FFFF) ? hit_cnt_reg
                                                               : hit_cnt_reg + 32'd1;
                    trk_we    = 1'b1;
                    trk_waddr = TRK_AW'(32'(bank_reg) * TRACK_DEPTH + 32'(hit_i_reg));
                    trk_wdata = {1'b1, row_reg, cnt_next};
                end
                else if (used_reg < cap && free_f_reg)
                begin
                    cnt_next  = 32'd1;
                    trk_we    = 1'b1;
                    trk_waddr = TRK_AW'(32'(bank_reg) * TRACK_DEPTH + 32'(free_i_reg));
                    trk_wdata = {1'b1, row_reg, 32'd1};
                end
                else if (ev_f_reg)
                begin
                    cnt_next  = (spill_cur == 32'hFFFF_FFFF) ? spill_cur : spill_cur + 32'd1;
                    trk_we    = 1'b1;
                    trk_waddr = TRK_AW'(32'(bank_reg) * TRACK_DEPTH + 32'(ev_i_reg));
                    trk_wdata = {1'b1, row_reg, cnt_next};
                end
                else if (spill_cur != 32'hFFFF_FFFF)
                begin
                    spill_next[bank_reg] = spill_cur + 32'd1;
                end
                if ((hit_f_reg || (used_reg < cap && free_f_reg) || ev_f_reg) &&
                    cfg.migrate_threshold != 16'd0)
                begin
                    div_start  = 1'b1;
                    div_dvd    = cnt_next;
                    state_next = ST_MDIV;
                end
            end

            ST_MDIV:
            begin
                if (div_done)
                begin
                    state_next = (div_rem == 32'd0) ? ST_QRD : ST_IDLE;
                end
            end

            // look up the head slot
            ST_QRD:
            begin
                state_next = ST_QCHK;
            end

            ST_QCHK:
            begin
                if (rev_rdata[REV_DW-1])
                begin
                    prev_next  = rev_rdata[ROW_BITS-1:0];
                    rev_we     = 1'b1;
                    state_next = ST_ERMQ;
                end
                else
                begin
                    state_next = ST_RRD;
                end
            end

            ST_ERMQ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REMOVE;
                    out_bank_next   = bank_reg;
                    out_first_next  = ROWF_W'(prev_reg);
                    out_second_next = slot_row;
                    out_last_next   = 1'b0;
                    state_next      = ST_EMGQ;
                end
            end

            ST_EMGQ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_MIGRATE;
                    out_bank_next   = bank_reg;
                    out_first_next  = slot_row;
                    out_second_next = ROWF_W'(prev_reg);
                    out_last_next   = 1'b0;
                    state_next      = ST_RRD;
                end
            end

            // activated row: quarantine slot or workload row
            ST_RRD:
            begin
                if (32'(row_reg) < 32'(qrows))
                begin
                    rev_raddr  = REV_AW'(32'(bank_reg) * MAX_QROWS + 32'(row_reg));
                    state_next = ST_RCHK;
                end
                else
                begin
                    rev_we     = 1'b1;
                    rev_wdata  = {1'b1, row_reg};
                    ins_next   = row_reg;
                    state_next = ST_EINS;
                end
            end

            ST_RCHK:
            begin
                if (rev_rdata[REV_DW-1])
                begin
                    prev_next  = rev_rdata[ROW_BITS-1:0];
                    rev_we     = 1'b1;
                    rev_waddr  = REV_AW'(32'(bank_reg) * MAX_QROWS + 32'(row_reg));
                    state_next = ST_RWR;
                end
                else
                begin
                    state_next = ST_EFIN;
                end
            end

            ST_RWR:
            begin
                rev_we     = 1'b1;
                rev_wdata  = {1'b1, prev_reg};
                ins_next   = prev_reg;
                state_next = ST_ERMR;
            end

            ST_ERMR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REMOVE;
                    out_bank_next   = bank_reg;
                    out_first_next  = ROWF_W'(prev_reg);
                    out_second_next = ROWF_W'(row_reg);
                    out_last_next   = 1'b0;
                    state_next      = ST_EINS;
                end
            end

            ST_EINS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_INSERT;
                    out_bank_next   = bank_reg;
                    out_first_next  = ROWF_W'(ins_reg);
                    out_second_next = slot_row;
                    out_last_next   = 1'b0;
                    state_next      = ST_EFIN;
                end
            end

            // final migrate, then wrap the head
            ST_EFIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_MIGRATE;
                    out_bank_next   = bank_reg;
                    out_first_next  = ROWF_W'(row_reg);
                    out_second_next = slot_row;
                    out_last_next   = 1'b1;
                    div_start       = 1'b1;
                    div_dvd         = 32'(head_reg) + 32'd1;
                    div_dvs         = 32'(qrows);
                    state_next      = ST_HDIV;
                end
            end

            ST_HDIV:
            begin
                if (div_done)
                begin
                    head_next  = SLOT_W'(div_rem);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            clr_rev_reg   <= 1'b1;
            scan_pend_reg <= 1'b0;
            head_reg      <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                spill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_rev_reg   <= clr_rev_next;
            scan_pend_reg <= scan_pend_next;
            head_reg      <= head_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            spill_reg     <= spill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg       <= bank_next;
        row_reg        <= row_next;
        scan_idx_reg   <= scan_idx_next;
        scan_pidx_reg  <= scan_pidx_next;
        used_reg       <= used_next;
        hit_f_reg      <= hit_f_next;
        hit_i_reg      <= hit_i_next;
        hit_cnt_reg    <= hit_cnt_next;
        free_f_reg     <= free_f_next;
        free_i_reg     <= free_i_next;
        ev_f_reg       <= ev_f_next;
        ev_i_reg       <= ev_i_next;
        cnt_reg        <= cnt_next;
        prev_reg       <= prev_next;
        ins_reg        <= ins_next;
        out_kind_reg   <= out_kind_next;
        out_bank_reg   <= out_bank_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_second_reg, out_first_reg, out_bank_reg};

    // checks
    a_last_is_migrate: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == KIND_MIGRATE)
        else $error("final result of an activation is not a migrate");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("remainder unit started while busy");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR |-> !s_tready)
        else $error("input taken during clearing pass");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !trk_we && !rev_we)
        else $error("table written during tracker scan");
endmodule

### sim/tb_aggressor_row_quarantine_tracker.sv
// ----------------------------------------------------------------------------
// tb_aggressor_row_quarantine_tracker
// Self-checking bench: a scoreboard class mirrors the per-bank aggressor
// tables, spillover counters, reverse table and rotating head, and checks
// every output transfer against the queued commands. The stimulus is a
// directed opener followed by random phases under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aggressor_row_quarantine_tracker;
    import aqrt_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BANK_W-1:0] bank;
        logic [15:0]       first_row;
        logic [15:0]       second_row;
        logic              last;
    } qcmd_t;

    class quarantine_scoreboard;
        logic [5:0]  tracker_entries;
        logic [15:0] migrate_threshold;
        logic [8:0]  quarantine_rows;
        logic [31:0] epoch_ticks;

        logic [15:0] trk_row [NUM_BANKS][TRACK_DEPTH];
        logic [31:0] trk_cnt [NUM_BANKS][TRACK_DEPTH];
        bit          trk_vld [NUM_BANKS][TRACK_DEPTH];
        logic [31:0] spill [NUM_BANKS];
        logic [15:0] rev_row [NUM_BANKS][MAX_QROWS];
        bit          rev_vld [NUM_BANKS][MAX_QROWS];
        int unsigned head;
        logic [31:0] ticks;

        qcmd_t pending_cmds[$];
        int    errors;
        int    n_acts, n_ticks, n_checked, n_migrations;

        function new();
            tracker_entries   = 6'd32;
            migrate_threshold = 16'd512;
            quarantine_rows   = 9'd256;
            epoch_ticks       = 32'd102400000;
            clear_counts();
            foreach (rev_vld[b, q]) rev_vld[b][q] = 1'b0;
            head  = 0;
            ticks = 0;
        endfunction

        function void clear_counts();
            foreach (trk_vld[b, i]) trk_vld[b][i] = 1'b0;
            foreach (spill[b]) spill[b] = 32'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_TRACKER_ENTRIES:   tracker_entries   = v[5:0];
                REG_MIGRATE_THRESHOLD: migrate_threshold = v[15:0];
                REG_QUARANTINE_ROWS:   quarantine_rows   = v[8:0];
                REG_EPOCH_TICKS:       epoch_ticks       = v;
                default: ;
            endcase
        endfunction

        function void push(logic [1:0] k, int b, logic [15:0] a, logic [15:0] d);
            qcmd_t c;
            c.kind = k; c.bank = BANK_W'(b); c.first_row = a; c.second_row = d;
            c.last = 1'b0;
            pending_cmds.push_back(c);
        endfunction

        // Note one accepted input transfer and queue the commands it causes
        function void note_input(logic cmd, logic [3:0] bank, logic [15:0] row);
            int          cap, used, hit, freei, evi, qrows, q, b;
            bit          found_hit, found_free, ev;
            logic [31:0] cnt;
            logic [15:0] prev;
            found_hit = 0; found_free = 0; ev = 0;
            used = 0; hit = 0; freei = 0; evi = 0;
            b = int'(bank);
            if (cmd == CMD_TICK) begin
                n_ticks++;
                ticks = ticks + 32'd1;
                if (epoch_ticks != 0 && ticks % epoch_ticks == 0) clear_counts();
                return;
            end
            n_acts++;
            cap = (tracker_entries > TRACK_DEPTH) ? TRACK_DEPTH : tracker_entries;
            // scan the bank's table for a hit and the first free entry
            for (int i = 0; i < TRACK_DEPTH; i++) begin
                if (trk_vld[b][i]) begin
                    used++;
                    if (!found_hit && trk_row[b][i] == row) begin
                        hit = i; found_hit = 1;
                    end
                end else if (!found_free) begin
                    freei = i; found_free = 1;
                end
            end
            if (found_hit) begin
                if (trk_cnt[b][hit] != 32'hFFFF_FFFF) trk_cnt[b][hit]++;
                cnt = trk_cnt[b][hit];
            end else if (used < cap && found_free) begin
                trk_vld[b][freei] = 1'b1;
                trk_row[b][freei] = row;
                trk_cnt[b][freei] = 32'd1;
                cnt = 32'd1;
            end else begin
                // spillover: evict the first entry matching the counter
                for (int i = 0; i < TRACK_DEPTH; i++) begin
                    if (!ev && trk_vld[b][i] && trk_cnt[b][i] == spill[b]) begin
                        evi = i; ev = 1;
                    end
                end
                if (!ev) begin
                    if (spill[b] != 32'hFFFF_FFFF) spill[b]++;
                    return;
                end
                cnt = (spill[b] == 32'hFFFF_FFFF) ? spill[b] : spill[b] + 32'd1;
                trk_row[b][evi] = row;
                trk_cnt[b][evi] = cnt;
            end
            if (migrate_threshold == 0 || cnt % migrate_threshold != 0) return;

            n_migrations++;
            qrows = (quarantine_rows == 0) ? 1 : quarantine_rows;
            if (qrows > MAX_QROWS) qrows = MAX_QROWS;
            q = head % MAX_QROWS;
            // send the current head occupant back home
            if (rev_vld[b][q]) begin
                prev = rev_row[b][q];
                rev_vld[b][q] = 1'b0;
                push(KIND_REMOVE, b, prev, 16'(q));
                push(KIND_MIGRATE, b, 16'(q), prev);
            end
            if (row < qrows) begin
                if (rev_vld[b][row]) begin
                    prev = rev_row[b][row];
                    rev_vld[b][row] = 1'b0;
                    push(KIND_REMOVE, b, prev, row);
                    rev_vld[b][q] = 1'b1;
                    rev_row[b][q] = prev;
                    push(KIND_INSERT, b, prev, 16'(q));
                end
            end else begin
                rev_vld[b][q] = 1'b1;
                rev_row[b][q] = row;
                push(KIND_INSERT, b, row, 16'(q));
            end
            push(KIND_MIGRATE, b, row, 16'(q));
            pending_cmds[$].last = 1'b1;
            head = (head + 1) % qrows;
        endfunction

        // Compare one output transfer with the oldest queued command
        function void check_result(qcmd_t got);
            qcmd_t exp;
            if (pending_cmds.size() == 0) begin
                $error("unexpected output transfer kind=%0d bank=%0d", got.kind, got.bank);
                errors++;
                return;
            end
            exp = pending_cmds.pop_front();
            n_checked++;
            if (got.kind !== exp.kind) begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind); errors++;
            end
            if (got.bank !== exp.bank) begin
                $error("out_bank: expected %0d, got %0d", exp.bank, got.bank); errors++;
            end
            if (got.first_row !== exp.first_row) begin
                $error("first_row: expected %h, got %h", exp.first_row, got.first_row);
                errors++;
            end
            if (got.second_row !== exp.second_row) begin
                $error("second_row: expected %h, got %h", exp.second_row, got.second_row);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;   // bank[3:0], row[19:4]
    logic                s_tuser;   // cmd
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;   // out_bank[3:0], first_row[19:4], second_row[35:20]
    logic [1:0]          m_tuser;   // kind
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    quarantine_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles_req;
    int hold_left;

    aggressor_row_quarantine_tracker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Drive the output ready: random stalls, or a long hold on request
    always @(posedge clk)
    begin
        if (hold_cycles_req > 0) begin
            hold_left = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        qcmd_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind       = m_tuser;
            got.bank       = m_tdata[3:0];
            got.first_row  = m_tdata[19:4];
            got.second_row = m_tdata[35:20];
            got.last       = m_tlast;
            sb.check_result(got);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic configure(logic [5:0] te, logic [15:0] thr, logic [8:0] qr,
                             logic [31:0] ep);
        reg_write(REG_TRACKER_ENTRIES, te);
        reg_write(REG_MIGRATE_THRESHOLD, thr);
        reg_write(REG_QUARANTINE_ROWS, qr);
        reg_write(REG_EPOCH_TICKS, ep);
    endtask

    // Offer one item and hold it until the transfer happens
    task automatic send_item(logic cmd, logic [3:0] bank, logic [15:0] row);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, row, bank};
        do @(posedge clk); while (!s_tready);
        sb.note_input(cmd, bank, row);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Pause the sender until every queued command has arrived, then settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic random_item();
        logic [3:0]  bank;
        logic [15:0] row;
        int          r;
        if ($urandom_range(99) < 20) begin
            send_item(CMD_TICK, 4'($urandom), 16'($urandom));
            return;
        end
        bank = ($urandom_range(99) < 75) ? 4'($urandom_range(3)) : 4'($urandom);
        r = $urandom_range(99);
        if (r < 40)      row = 16'($urandom_range(5));
        else if (r < 80) row = 16'h0100 << $urandom_range(7);
        else             row = 16'($urandom);
        send_item(CMD_ACT, bank, row);
    endtask

    initial
    begin
        logic [5:0]  te_set  [8] = '{6'd4, 6'd1, 6'd3, 6'd32, 6'd0, 6'd63, 6'd6, 6'd2};
        logic [15:0] thr_set [8] = '{16'd2, 16'd1, 16'd3, 16'd1, 16'd1, 16'hFFFF,
                                     16'd2, 16'd1};
        logic [8:0]  qr_set  [8] = '{9'd8, 9'd1, 9'd0, 9'd256, 9'd16, 9'd511,
                                     9'd5, 9'd3};
        logic [31:0] ep_set  [8] = '{32'd50, 32'd0, 32'd7, 32'd1, 32'd0,
                                     32'hFFFF_FFFF, 32'd20, 32'd9};
        clk = 1'b0; rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = CMD_TICK; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle_pct = 8; recv_stall_pct = 60;
        hold_cycles_req = 0; hold_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opener: small table, threshold one, four quarantine slots
        configure(6'd2, 16'd1, 9'd4, 32'd3);
        send_item(CMD_ACT, 4'd0, 16'h0005);
        send_item(CMD_ACT, 4'd15, 16'hFFFF);
        send_item(CMD_ACT, 4'd0, 16'h0002);     // quarantine row with no mapping
        send_item(CMD_ACT, 4'd0, 16'h0005);     // hit
        send_item(CMD_ACT, 4'd0, 16'h0000);     // full table, spillover grows
        send_item(CMD_ACT, 4'd0, 16'hAAAA);     // evicts on the spill count
        send_item(CMD_ACT, 4'd0, 16'h5555);     // full table, spillover grows again
        send_item(CMD_ACT, 4'd0, 16'h0001);     // quarantine row with no mapping
        send_item(CMD_ACT, 4'd0, 16'h0000);
        send_item(CMD_TICK, 4'd0, 16'h0000);
        send_item(CMD_TICK, 4'd15, 16'hFFFF);
        send_item(CMD_TICK, 4'd0, 16'h0000);    // epoch end clears the counts
        send_item(CMD_ACT, 4'd0, 16'h0005);
        send_item(CMD_ACT, 4'd7, 16'h8000);
        send_item(CMD_ACT, 4'd0, 16'h0003);
        send_item(CMD_ACT, 4'd0, 16'h0002);
        send_item(CMD_ACT, 4'd15, 16'h0000);
        send_item(CMD_ACT, 4'd15, 16'h0001);
        send_item(CMD_ACT, 4'd15, 16'hFFFF);
        drain();

        // Random phases over the register settings
        for (int p = 0; p < 8; p++) begin
            configure(te_set[p], thr_set[p], qr_set[p], ep_set[p]);
            send_idle_pct  = (p < 3) ? 8 : (p < 6) ? 60 : 0;
            recv_stall_pct = (p < 3) ? 60 : (p < 6) ? 8 : 0;
            for (int k = 0; k < 55; k++) begin
                if (p == 6 && k == 5) hold_cycles_req = 1500;
                random_item();
            end
            drain();
        end

        $display("covered %0d activations and %0d ticks over 9 register settings",
                 sb.n_acts, sb.n_ticks);
        $display("checked %0d commands from %0d migrations", sb.n_checked, sb.n_migrations);
        if (sb.errors == 0 && sb.pending_cmds.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
